// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define SRTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SRTF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/srtf_pkg.sv -----
package srtf_pkg;

  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;

  // result status codes
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_ZERO = 2'd2;

  // request codes
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_ARRIVE = 1'b1;

  // per-beat table command
  typedef struct packed {
    logic admit;  // write a new job at the free slot
    logic run;    // run the selected slot for one time unit
  } slot_cmd_t;

endpackage

// ----- sv/srtf_scheduler.sv -----
// An accepted input beat is held in the input register, then its result beat in
// the result register. Throughput: one beat per cycle unless the result is stalled;
// slot update, minimum tree and free-slot search settle between the two registers.
// Reset (rst, synchronous): clears time, all slot valid/started flags and both
// pipeline valids; slot payload is left unreset and is only read once written.
module srtf_scheduler #(
  parameter int SLOTS       = 16,
  parameter int BURST_WIDTH = 16,
  parameter int ID_WIDTH    = 8,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [ID_WIDTH-1:0]    job_id,
  input  logic [BURST_WIDTH-1:0] burst_length,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output srtf_pkg::status_t      status,
  output logic [ID_WIDTH-1:0]    done_id,
  output logic [TIME_WIDTH-1:0]  run_start,
  output logic [TIME_WIDTH-1:0]  finish_time,
  output logic [TIME_WIDTH-1:0]  turnaround_time,
  output logic [TIME_WIDTH-1:0]  resp_time,
  output logic [TIME_WIDTH-1:0]  wait_time
);
  import srtf_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);

  // ---------------------------------------------------------------------------
  // Input register. One beat waits here while the table is consulted.
  // ---------------------------------------------------------------------------
  logic                   s1_valid;
  logic                   s1_req;
  logic [ID_WIDTH-1:0]    s1_id;
  logic [BURST_WIDTH-1:0] s1_burst;

  logic in_accept;
  logic adv;  // input register beat is processed this cycle

  // the beat can retire whenever the result register is empty or draining
  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req   <= req_type;
      s1_id    <= job_id;
      s1_burst <= burst_length;
    end
  end

  // ---------------------------------------------------------------------------
  // Time base. Only ticks advance it; wraps naturally at 2^TIME_WIDTH.
  // ---------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] now_inc;
  logic                  is_tick;

  assign is_tick = (s1_req == REQ_TICK);
  assign now_inc = now + TIME_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (adv && is_tick) begin
      now <= now_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot table and selection trees
  // ---------------------------------------------------------------------------
  logic [SLOTS-1:0]                  valid_vec;
  logic [SLOTS-1:0][BURST_WIDTH-1:0] rem_vec;
  logic                              run_found;
  logic [SLOT_W-1:0]                 run_idx;
  logic                              free_found;
  logic [SLOT_W-1:0]                 free_idx;
  logic [ID_WIDTH-1:0]               sel_id;
  logic [TIME_WIDTH-1:0]             sel_arrival;
  logic [TIME_WIDTH-1:0]             sel_start;
  logic [TIME_WIDTH-1:0]             sel_due;
  logic                              sel_started;
  logic                              sel_last;
  slot_cmd_t                         cmd;
  logic                              zero_burst;
  logic [TIME_WIDTH-1:0]             due;

  srtf_select #(
    .SLOTS       (SLOTS),
    .BURST_WIDTH (BURST_WIDTH)
  ) u_select (
    .valid_vec  (valid_vec),
    .rem_vec    (rem_vec),
    .run_found  (run_found),
    .run_idx    (run_idx),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  assign zero_burst = (s1_burst == '0);
  // arrival plus burst, so the wait time is a single subtract at completion
  assign due        = now + TIME_WIDTH'(s1_burst);

  assign cmd.admit = adv && !is_tick && !zero_burst && free_found;
  assign cmd.run   = adv && is_tick && run_found;

  srtf_slot_table #(
    .SLOTS       (SLOTS),
    .ID_WIDTH    (ID_WIDTH),
    .BURST_WIDTH (BURST_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_table (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .wr_idx      (free_idx),
    .wr_id       (s1_id),
    .wr_burst    (s1_burst),
    .wr_due      (due),
    .run_idx     (run_idx),
    .now_time    (now),
    .valid_vec   (valid_vec),
    .rem_vec     (rem_vec),
    .sel_id      (sel_id),
    .sel_arrival (sel_arrival),
    .sel_start   (sel_start),
    .sel_due     (sel_due),
    .sel_started (sel_started),
    .sel_last    (sel_last)
  );

  // ---------------------------------------------------------------------------
  // Result formation. A completion happens when the picked job has one unit
  // left; a reject when the burst is zero (checked first) or no slot is free.
  // ---------------------------------------------------------------------------
  logic                  res_done;
  logic                  res_rej;
  logic [TIME_WIDTH-1:0] start_eff;
  logic [TIME_WIDTH-1:0] ta;

  assign res_done  = is_tick && run_found && sel_last;
  assign res_rej   = !is_tick && (zero_burst || !free_found);
  // a job that finishes on its first unit starts now
  assign start_eff = sel_started ? sel_start : now;
  assign ta        = now_inc - sel_arrival;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && (res_done || res_rej)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_done) begin
      status          <= ST_DONE;
      done_id         <= sel_id;
      run_start       <= start_eff;
      finish_time     <= now_inc;
      turnaround_time <= ta;
      resp_time       <= start_eff - sel_arrival;
      wait_time       <= now_inc - sel_due;
    end else if (adv && res_rej) begin
      status          <= zero_burst ? ST_ZERO : ST_FULL;
      done_id         <= s1_id;
      run_start       <= '0;
      finish_time     <= '0;
      turnaround_time <= '0;
      resp_time       <= '0;
      wait_time       <= '0;
    end
  end

endmodule

// ----- sv/srtf_select.sv -----
module srtf_select #(
  parameter int SLOTS       = 16,
  parameter int BURST_WIDTH = 16
) (
  input  logic [SLOTS-1:0]                  valid_vec,
  input  logic [SLOTS-1:0][BURST_WIDTH-1:0] rem_vec,
  output logic                              run_found,
  output logic [$clog2(SLOTS)-1:0]          run_idx,
  output logic                              free_found,
  output logic [$clog2(SLOTS)-1:0]          free_idx
);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int NP     = 1 << SLOT_W;

  // heap-ordered trees: node k has children 2k and 2k+1, leaves at NP+i
  logic                   min_v   [1:2*NP-1];
  logic [BURST_WIDTH-1:0] min_r   [1:2*NP-1];
  logic [SLOT_W-1:0]      min_i   [1:2*NP-1];
  logic                   free_v  [1:2*NP-1];
  logic [SLOT_W-1:0]      free_i  [1:2*NP-1];

  for (genvar g = 0; g < NP; g++) begin : g_leaf
    if (g < SLOTS) begin : g_real
      assign min_v[NP+g]  = valid_vec[g];
      assign min_r[NP+g]  = rem_vec[g];
      assign free_v[NP+g] = ~valid_vec[g];
    end else begin : g_pad
      assign min_v[NP+g]  = 1'b0;
      assign min_r[NP+g]  = '0;
      assign free_v[NP+g] = 1'b0;
    end
    assign min_i[NP+g]  = SLOT_W'(g);
    assign free_i[NP+g] = SLOT_W'(g);
  end

  // left child holds the lower slots, so it wins ties
  for (genvar k = 1; k < NP; k++) begin : g_node
    logic take_l;
    assign take_l    = min_v[2*k] && (!min_v[2*k+1] || (min_r[2*k] <= min_r[2*k+1]));
    assign min_v[k]  = min_v[2*k] | min_v[2*k+1];
    assign min_r[k]  = take_l ? min_r[2*k] : min_r[2*k+1];
    assign min_i[k]  = take_l ? min_i[2*k] : min_i[2*k+1];
    assign free_v[k] = free_v[2*k] | free_v[2*k+1];
    assign free_i[k] = free_v[2*k] ? free_i[2*k] : free_i[2*k+1];
  end

  assign run_found  = min_v[1];
  assign run_idx    = min_i[1];
  assign free_found = free_v[1];
  assign free_idx   = free_i[1];

endmodule

// ----- sv/srtf_slot_table.sv -----
module srtf_slot_table #(
  parameter int SLOTS       = 16,
  parameter int ID_WIDTH    = 8,
  parameter int BURST_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  srtf_pkg::slot_cmd_t               cmd,
  input  logic [$clog2(SLOTS)-1:0]          wr_idx,
  input  logic [ID_WIDTH-1:0]               wr_id,
  input  logic [BURST_WIDTH-1:0]            wr_burst,
  input  logic [TIME_WIDTH-1:0]             wr_due,
  input  logic [$clog2(SLOTS)-1:0]          run_idx,
  input  logic [TIME_WIDTH-1:0]             now_time,
  output logic [SLOTS-1:0]                  valid_vec,
  output logic [SLOTS-1:0][BURST_WIDTH-1:0] rem_vec,
  output logic [ID_WIDTH-1:0]               sel_id,
  output logic [TIME_WIDTH-1:0]             sel_arrival,
  output logic [TIME_WIDTH-1:0]             sel_start,
  output logic [TIME_WIDTH-1:0]             sel_due,
  output logic                              sel_started,
  output logic                              sel_last
);
  import srtf_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);

  logic [SLOTS-1:0]       slot_valid;
  logic [SLOTS-1:0]       slot_started;
  logic [ID_WIDTH-1:0]    slot_id      [SLOTS];
  logic [BURST_WIDTH-1:0] slot_rem     [SLOTS];
  logic [TIME_WIDTH-1:0]  slot_arrival [SLOTS];
  logic [TIME_WIDTH-1:0]  slot_start   [SLOTS];
  logic [TIME_WIDTH-1:0]  slot_due     [SLOTS];  // arrival plus burst

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      slot_started <= '0;
    end else if (cmd.admit) begin
      slot_valid[wr_idx]   <= 1'b1;
      slot_started[wr_idx] <= 1'b0;
    end else if (cmd.run) begin
      slot_started[run_idx] <= !sel_last;
      if (sel_last) begin
        slot_valid[run_idx] <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.admit && (wr_idx == SLOT_W'(g))) begin
        slot_id[g]      <= wr_id;
        slot_rem[g]     <= wr_burst;
        slot_arrival[g] <= now_time;
        slot_due[g]     <= wr_due;
      end else if (cmd.run && (run_idx == SLOT_W'(g))) begin
        slot_rem[g] <= slot_rem[g] - BURST_WIDTH'(1);
        if (!slot_started[g]) begin
          slot_start[g] <= now_time;
        end
      end
    end
    assign rem_vec[g] = slot_rem[g];
  end

  assign valid_vec   = slot_valid;
  assign sel_id      = slot_id[run_idx];
  assign sel_arrival = slot_arrival[run_idx];
  assign sel_start   = slot_start[run_idx];
  assign sel_due     = slot_due[run_idx];
  assign sel_started = slot_started[run_idx];
  assign sel_last    = (slot_rem[run_idx] == BURST_WIDTH'(1));

endmodule

// ----- sv/srtf_checker.sv -----
`include "assert_macros.svh"

module srtf_checker #(
  parameter int TIME_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input srtf_pkg::status_t     status,
  input logic [TIME_WIDTH-1:0] run_start,
  input logic [TIME_WIDTH-1:0] finish_time,
  input logic [TIME_WIDTH-1:0] turnaround_time,
  input logic [TIME_WIDTH-1:0] resp_time,
  input logic [TIME_WIDTH-1:0] wait_time
);
  import srtf_pkg::*;

  logic                             held;
  logic                             is_reject;
  logic                             is_done;
  logic                             times_clear;
  logic                             times_agree;
  logic [STATUS_W+5*TIME_WIDTH-1:0] res_word;

  assign held        = out_valid && out_stall;
  assign is_reject   = out_valid && (status != ST_DONE);
  assign is_done     = out_valid && (status == ST_DONE);
  assign res_word    = {status, run_start, finish_time, turnaround_time, resp_time, wait_time};
  assign times_clear = (run_start == '0) && (finish_time == '0) && (turnaround_time == '0) &&
                       (resp_time == '0) && (wait_time == '0);
  assign times_agree = (TIME_WIDTH'(turnaround_time - resp_time) ==
                        TIME_WIDTH'(finish_time - run_start));

  `SRTF_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")

  `SRTF_ASSERT(a_hold_stalled, held |=> out_valid && $stable(res_word), "stalled beat changed")

  `SRTF_ASSERT(a_no_stall_when_empty, !out_valid |-> !in_stall, "stall with empty output")

  `SRTF_ASSERT(a_reject_zero_times, is_reject |-> times_clear, "reject carries nonzero times")

  `SRTF_ASSERT(a_time_relation, is_done |-> times_agree, "inconsistent completion times")

endmodule

bind srtf_scheduler srtf_checker #(
  .TIME_WIDTH (TIME_WIDTH)
) u_srtf_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .status          (status),
  .run_start       (run_start),
  .finish_time     (finish_time),
  .turnaround_time (turnaround_time),
  .resp_time       (resp_time),
  .wait_time       (wait_time)
);
